// File: rtl/matrix_keypad_scanner_core_macros.svh
// assertion macros used by the checker file
`ifndef MATRIX_KEYPAD_SCANNER_CORE_MACROS_SVH
`define MATRIX_KEYPAD_SCANNER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MKS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define MKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mks_pkg.sv
`default_nettype none
package mks_pkg;

    localparam int NUM_ROWS_DEF = 4;
    localparam int NUM_COLS     = 4;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    typedef logic [7:0]  t_key;
    typedef logic [15:0] t_ticks;
    typedef logic [7:0]  t_settle;

    localparam t_ticks  SCAN_INTERVAL_RST = 16'd100;
    localparam t_settle SETTLE_CYCLES_RST = 8'd100;
    localparam t_ticks  TICKS_MAX         = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_CYCLES = 1'b1;

    localparam t_key KEY_NONE = 8'h00;

    // 1 2 3 + / 4 5 6 - / 7 8 9 * / C 0 = /
    function automatic t_key key_lookup(input logic [2:0] row, input logic [1:0] col);
        t_key k;
        k = KEY_NONE;
        case (row)
            3'd0: begin
                case (col)
                    2'd0: k = "1";
                    2'd1: k = "2";
                    2'd2: k = "3";
                    default: k = "+";
                endcase
            end
            3'd1: begin
                case (col)
                    2'd0: k = "4";
                    2'd1: k = "5";
                    2'd2: k = "6";
                    default: k = "-";
                endcase
            end
            3'd2: begin
                case (col)
                    2'd0: k = "7";
                    2'd1: k = "8";
                    2'd2: k = "9";
                    default: k = "*";
                endcase
            end
            3'd3: begin
                case (col)
                    2'd0: k = "C";
                    2'd1: k = "0";
                    2'd2: k = "=";
                    default: k = "/";
                endcase
            end
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// File: rtl/matrix_keypad_scanner_core.sv
// result registered in the output register when the input transaction is accepted
// throughput: one transaction per cycle while the output side accepts, a result may wait in the output register
// while the next input is taken if the output side accepts in the same cycle
// reset (synchronous, active low): scan state, tick count and held key cleared,
// scan_interval and settle_cycles back to 100, output register empty
`default_nettype none
module matrix_keypad_scanner_core #(
    parameter int NUM_ROWS = mks_pkg::NUM_ROWS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [mks_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [mks_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // time_tick [0], column_levels [4:1], zero [7:5]
    input  wire logic [mks_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // row_drive [3:0], held_key [11:4], new_key [12], scan_done [13], zero [15:14]
    output logic [mks_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

    localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam logic [RW-1:0] ROW_LAST = RW'(NUM_ROWS - 1);

    mks_pkg::t_ticks  r_scan_interval;
    mks_pkg::t_settle r_settle_cycles;

    mks_pkg::t_ticks  r_elapsed, n_elapsed;
    logic             r_scanning, n_scanning;
    logic [RW-1:0]    r_row, n_row;
    mks_pkg::t_settle r_settle_cnt, n_settle_cnt;
    mks_pkg::t_key    r_last_key, n_last_key;

    logic             r_out_valid;
    logic [3:0]       r_out_row_drive, n_row_drive;
    mks_pkg::t_key    r_out_key;
    logic             r_out_new_key, n_new_key;
    logic             r_out_scan_done, n_scan_done;

    logic             in_tick;
    logic [3:0]       in_levels;
    logic             accept;
    mks_pkg::t_ticks  ticks_inc;
    mks_pkg::t_settle settle_need;
    mks_pkg::t_settle settle_inc;
    logic             found;
    logic [1:0]       found_col;
    mks_pkg::t_key    key;
    logic [2:0]       row_wide;

    assign in_tick   = s_axis_tdata[0];
    assign in_levels = s_axis_tdata[4:1];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign row_wide = 3'(r_row);

    // lowest pressed column of the current row
    always_comb begin
        found     = 1'b0;
        found_col = 2'd0;
        for (int c = mks_pkg::NUM_COLS - 1; c >= 0; c--) begin
            if (!in_levels[c]) begin
                found     = 1'b1;
                found_col = 2'(c);
            end
        end
    end

    always_comb begin
        ticks_inc    = (in_tick && r_elapsed != mks_pkg::TICKS_MAX) ?
                       r_elapsed + 16'd1 : r_elapsed;
        settle_need  = (r_settle_cycles == 8'd0) ? 8'd1 : r_settle_cycles;
        settle_inc   = r_settle_cnt + 8'd1;
        key          = found ? mks_pkg::key_lookup(row_wide, found_col) : mks_pkg::KEY_NONE;

        n_elapsed    = ticks_inc;
        n_scanning   = r_scanning;
        n_row        = r_row;
        n_settle_cnt = r_settle_cnt;
        n_last_key   = r_last_key;
        n_new_key    = 1'b0;
        n_scan_done  = 1'b0;

        if (!r_scanning) begin
            if (ticks_inc > r_scan_interval) begin
                n_elapsed    = '0;
                n_scanning   = 1'b1;
                n_row        = '0;
                n_settle_cnt = '0;
            end
        end else begin
            n_settle_cnt = settle_inc;
            if (settle_inc >= settle_need) begin
                n_settle_cnt = '0;
                if (found || r_row == ROW_LAST) begin
                    if (key != mks_pkg::KEY_NONE && key != r_last_key) begin
                        n_last_key = key;
                        n_new_key  = 1'b1;
                    end else if (key == mks_pkg::KEY_NONE) begin
                        n_last_key = mks_pkg::KEY_NONE;
                    end
                    n_scanning  = 1'b0;
                    n_row       = '0;
                    n_scan_done = 1'b1;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end
        end

        n_row_drive = 4'hF;
        if (n_scanning && 32'(n_row) < 32'd4) begin
            n_row_drive = ~(4'b0001 << 3'(n_row));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_interval <= mks_pkg::SCAN_INTERVAL_RST;
            r_settle_cycles <= mks_pkg::SETTLE_CYCLES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mks_pkg::CFG_SCAN_INTERVAL: r_scan_interval <= i_cfg_data;
                mks_pkg::CFG_SETTLE_CYCLES: r_settle_cycles <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed    <= '0;
            r_scanning   <= 1'b0;
            r_row        <= '0;
            r_settle_cnt <= '0;
            r_last_key   <= mks_pkg::KEY_NONE;
        end else if (accept) begin
            r_elapsed    <= n_elapsed;
            r_scanning   <= n_scanning;
            r_row        <= n_row;
            r_settle_cnt <= n_settle_cnt;
            r_last_key   <= n_last_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_row_drive <= n_row_drive;
            r_out_key       <= n_last_key;
            r_out_new_key   <= n_new_key;
            r_out_scan_done <= n_scan_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_scan_done, r_out_new_key, r_out_key, r_out_row_drive};

endmodule
`default_nettype wire

// File: rtl/mks_checker.sv
`default_nettype none
`include "matrix_keypad_scanner_core_macros.svh"
module mks_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [mks_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // empty output register never blocks the input
    `MKS_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

    // a new key only comes with the end of a scan and is never the empty key
    `MKS_ASSERT_SAME(a_new_key_on_done, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[12], m_axis_tdata[13] && m_axis_tdata[11:4] != 8'h00, "new key outside a finished scan")

    // at most one row driven low
    `MKS_ASSERT_SAME(a_one_row, i_clk, i_rst_n, m_axis_tvalid, $onehot0(~m_axis_tdata[3:0]), "more than one row driven")

    // a result accepted on the input shows on the output next cycle
    `MKS_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "accepted transaction produced no result")

    // a stalled result stays
    `MKS_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind matrix_keypad_scanner_core mks_checker u_mks_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// File: tb/matrix_keypad_scanner_core_test.sv
`default_nettype none
module matrix_keypad_scanner_core_test;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LAST_ROW    = mks_pkg::NUM_ROWS_DEF - 1;
    localparam logic [127:0] KEYPAD = "123+456-789*C0=/";

    // output fields from the lowest bit up: row_drive, held_key, new_key, scan_done, zero
    typedef struct packed {
        logic [1:0]    pad;
        logic          scan_done;
        logic          new_key;
        mks_pkg::t_key held_key;
        logic [3:0]    row_drive;
    } t_scan_out;

    typedef struct packed {
        logic          tick;
        logic [3:0]    cols;
        logic          typed;
        logic [3:0]    rows;
        mks_pkg::t_key held;
        logic          fresh;
        logic          done;
    } t_probe;

    localparam int N_DIRECTED = 25;
    localparam t_probe DIRECTED [N_DIRECTED] = '{
        '{1'b0, 4'hF, 1'b1, 4'hF, 8'h00, 1'b0, 1'b0},
        '{1'b1, 4'hF, 1'b1, 4'hE, 8'h00, 1'b0, 1'b0},
        '{1'b0, 4'hE, 1'b1, 4'hF, 8'h31, 1'b1, 1'b1},
        '{1'b1, 4'hF, 1'b1, 4'hE, 8'h31, 1'b0, 1'b0},
        '{1'b0, 4'hE, 1'b1, 4'hF, 8'h31, 1'b0, 1'b1},
        '{1'b1, 4'hF, 1'b1, 4'hE, 8'h31, 1'b0, 1'b0},
        '{1'b1, 4'hF, 1'b0, 4'h0, 8'h00, 1'b0, 1'b0},
        '{1'b0, 4'hF, 1'b0, 4'h0, 8'h00, 1'b0, 1'b0},
        '{1'b0, 4'hF, 1'b0, 4'h0, 8'h00, 1'b0, 1'b0},
        '{1'b0, 4'hF, 1'b1, 4'hF, 8'h00, 1'b0, 1'b1},
        '{1'b0, 4'hF, 1'b1, 4'hE, 8'h00, 1'b0, 1'b0},
        '{1'b0, 4'h7, 1'b1, 4'hF, 8'h2B, 1'b1, 1'b1},
        '{1'b1, 4'h0, 1'b1, 4'hE, 8'h2B, 1'b0, 1'b0},
        '{1'b0, 4'h0, 1'b1, 4'hF, 8'h31, 1'b1, 1'b1},
        '{1'b1, 4'hF, 1'b1, 4'hE, 8'h31, 1'b0, 1'b0},
        '{1'b0, 4'hF, 1'b0, 4'h0, 8'h00, 1'b0, 1'b0},
        '{1'b0, 4'hF, 1'b0, 4'h0, 8'h00, 1'b0, 1'b0},
        '{1'b0, 4'h5, 1'b1, 4'hF, 8'h38, 1'b1, 1'b1},
        '{1'b1, 4'hF, 1'b1, 4'hE, 8'h38, 1'b0, 1'b0},
        '{1'b0, 4'hF, 1'b0, 4'h0, 8'h00, 1'b0, 1'b0},
        '{1'b0, 4'hF, 1'b0, 4'h0, 8'h00, 1'b0, 1'b0},
        '{1'b0, 4'hF, 1'b0, 4'h0, 8'h00, 1'b0, 1'b0},
        '{1'b0, 4'h5, 1'b1, 4'hF, 8'h30, 1'b1, 1'b1},
        '{1'b1, 4'hB, 1'b1, 4'hE, 8'h30, 1'b0, 1'b0},
        '{1'b0, 4'hB, 1'b1, 4'hF, 8'h33, 1'b1, 1'b1}
    };

    localparam int N_SETTINGS = 9;
    localparam mks_pkg::t_ticks  INTERVALS [N_SETTINGS] = '{16'd0, 16'd1, 16'd3, 16'd0, 16'd2,
                                                            16'hFFFF, 16'd5, 16'd0, 16'd17};
    localparam mks_pkg::t_settle SETTLES   [N_SETTINGS] = '{8'd0, 8'd1, 8'd2, 8'd255, 8'd3,
                                                            8'd7, 8'd1, 8'd4, 8'd2};
    localparam int BURSTS [N_SETTINGS] = '{130, 130, 130, 400, 130, 60, 130, 130, 130};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [mks_pkg::CFG_IDX_W-1:0] i_cfg_idx = mks_pkg::CFG_SCAN_INTERVAL;
    logic [mks_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // time_tick [0], column_levels [4:1], zero [7:5]
    logic [mks_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // row_drive [3:0], held_key [11:4], new_key [12], scan_done [13], zero [15:14]
    logic [mks_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    matrix_keypad_scanner_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // scanner mirror
    mks_pkg::t_ticks  cfg_interval = mks_pkg::SCAN_INTERVAL_RST;
    mks_pkg::t_settle cfg_settle   = mks_pkg::SETTLE_CYCLES_RST;
    mks_pkg::t_ticks  tick_count   = '0;
    logic             scan_busy    = 1'b0;
    logic [1:0]       scan_row     = 2'd0;
    mks_pkg::t_settle dwell        = '0;
    mks_pkg::t_key    held_now     = mks_pkg::KEY_NONE;

    t_scan_out due_outputs [$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int items_in = 0;
    int results_checked = 0;
    int scans_seen = 0;
    int keys_seen = 0;
    int cycle_count = 0;

    function automatic t_scan_out advance_scanner(input logic tick, input logic [3:0] cols);
        t_scan_out r;
        int need;
        int c;
        logic hit;
        mks_pkg::t_key key;
        r = '0;
        hit = 1'b0;
        key = mks_pkg::KEY_NONE;
        if (tick && tick_count != mks_pkg::TICKS_MAX)
            tick_count = tick_count + 1'b1;
        if (!scan_busy) begin
            if (tick_count > cfg_interval) begin
                tick_count = '0;
                scan_busy = 1'b1;
                scan_row = 2'd0;
                dwell = '0;
            end
        end else begin
            need = (cfg_settle == 0) ? 1 : int'(cfg_settle);
            dwell = dwell + 1'b1;
            if (int'(dwell) >= need) begin
                // lowest pressed column wins
                for (c = mks_pkg::NUM_COLS - 1; c >= 0; c--) begin
                    if (!cols[c]) begin
                        hit = 1'b1;
                        key = KEYPAD[127 - 8 * (4 * int'(scan_row) + c) -: 8];
                    end
                end
                dwell = '0;
                if (hit || int'(scan_row) == LAST_ROW) begin
                    if (key != mks_pkg::KEY_NONE && key != held_now) begin
                        held_now = key;
                        r.new_key = 1'b1;
                    end else if (key == mks_pkg::KEY_NONE) begin
                        held_now = mks_pkg::KEY_NONE;
                    end
                    scan_busy = 1'b0;
                    scan_row = 2'd0;
                    r.scan_done = 1'b1;
                end else begin
                    scan_row = scan_row + 1'b1;
                end
            end
        end
        r.row_drive = scan_busy ? ~(4'b0001 << scan_row) : 4'hF;
        r.held_key = held_now;
        return r;
    endfunction

    task automatic send_item(input logic tick, input logic [3:0] cols, input logic typed,
                             input t_scan_out fixed);
        t_scan_out predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, cols, tick};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predicted = advance_scanner(tick, cols);
        due_outputs.push_back(typed ? fixed : predicted);
        items_in++;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (due_outputs.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_config(input mks_pkg::t_ticks interval, input mks_pkg::t_settle settle);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= mks_pkg::CFG_SCAN_INTERVAL;
        i_cfg_data <= interval;
        @(posedge i_clk);
        i_cfg_idx <= mks_pkg::CFG_SETTLE_CYCLES;
        i_cfg_data <= mks_pkg::CFG_DATA_W'(settle);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_interval = interval;
        cfg_settle = settle;
    endtask

    // key presses seen through the row drive, with release, noise and bounce stretches
    task automatic random_burst(input int count);
        int left;
        int span;
        int mode;
        int k;
        logic [1:0] row_a;
        logic [1:0] row_b;
        logic [1:0] col_a;
        logic [1:0] col_b;
        logic two_keys;
        logic tick;
        logic [3:0] cols;
        left = count;
        while (left > 0) begin
            span = $urandom_range(40, 3);
            mode = $urandom_range(9);
            row_a = 2'($urandom_range(3));
            col_a = 2'($urandom_range(3));
            row_b = 2'($urandom_range(3));
            col_b = 2'($urandom_range(3));
            two_keys = ($urandom_range(4) == 0);
            for (k = 0; k < span && left > 0; k++) begin
                tick = ($urandom_range(99) < 60);
                if (mode < 2) begin
                    cols = 4'($urandom_range(15));
                end else if (mode < 3) begin
                    cols = 4'hF;
                end else begin
                    cols = 4'hF;
                    if (scan_busy && scan_row == row_a)
                        cols[col_a] = 1'b0;
                    if (two_keys && scan_busy && scan_row == row_b)
                        cols[col_b] = 1'b0;
                    if ($urandom_range(19) == 0)
                        cols = 4'($urandom_range(15));
                end
                send_item(tick, cols, 1'b0, '0);
                left--;
            end
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : check_out
        t_scan_out got;
        t_scan_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (due_outputs.size() == 0) begin
                $error("output transaction with none outstanding: %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = due_outputs.pop_front();
                results_checked++;
                if (got.scan_done)
                    scans_seen++;
                if (got.new_key)
                    keys_seen++;
                if (got.row_drive !== want.row_drive) begin
                    $error("row_drive: expected %h, got %h", want.row_drive, got.row_drive);
                    mismatches++;
                end
                if (got.held_key !== want.held_key) begin
                    $error("held_key: expected %h, got %h", want.held_key, got.held_key);
                    mismatches++;
                end
                if (got.new_key !== want.new_key) begin
                    $error("new_key: expected %b, got %b", want.new_key, got.new_key);
                    mismatches++;
                end
                if (got.scan_done !== want.scan_done) begin
                    $error("scan_done: expected %b, got %b", want.scan_done, got.scan_done);
                    mismatches++;
                end
                if (got.pad !== want.pad) begin
                    $error("reserved bits: expected %b, got %b", want.pad, got.pad);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : run
        t_scan_out fixed;
        int i;
        int phase;
        int s;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 38;
        recv_idle_pct = 76;
        set_config(16'd0, 8'd1);
        for (i = 0; i < N_DIRECTED; i++) begin
            fixed = '0;
            fixed.row_drive = DIRECTED[i].rows;
            fixed.held_key = DIRECTED[i].held;
            fixed.new_key = DIRECTED[i].fresh;
            fixed.scan_done = DIRECTED[i].done;
            send_item(DIRECTED[i].tick, DIRECTED[i].cols, DIRECTED[i].typed, fixed);
        end

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 76 : 0;
            recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 38 : 0;
            for (s = 3 * phase; s < 3 * phase + 3; s++) begin
                drain;
                set_config(INTERVALS[s], SETTLES[s]);
                random_burst(BURSTS[s]);
            end
        end

        drain;
        repeat (4) @(posedge i_clk);
        $display("%0d input transactions, %0d results checked, %0d scans, %0d new keys",
                 items_in, results_checked, scans_seen, keys_seen);
        $display("settle 0 to 255, interval 0 to 65535, three idling mixes");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/mks_pkg.sv
rtl/matrix_keypad_scanner_core.sv
rtl/mks_checker.sv
tb/matrix_keypad_scanner_core_test.sv
